[rtl/grba_pkg.sv]
`default_nettype none
package grba_pkg;

  // grid size limits
  localparam int MAX_COLS = 16;
  localparam int MAX_ROWS = 16;

  // row index, free-row run counter and extended compare widths
  localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RUNW = $clog2(MAX_ROWS + 1);
  localparam int EW   = 8;

  // field widths
  localparam int FUNCW  = 3;
  localparam int XW     = 4;
  localparam int YW     = 4;
  localparam int SZW    = 5;
  localparam int CFGW   = 5;
  localparam int CFG_IW = 1;

  // config register indexes and reset values
  localparam logic [CFG_IW-1:0] REG_GRID_COLS = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] REG_GRID_ROWS = CFG_IW'(1);
  localparam logic [CFGW-1:0]   GRID_COLS_RST = CFGW'(16);
  localparam logic [CFGW-1:0]   GRID_ROWS_RST = CFGW'(16);

  typedef enum logic [2:0] {
    F_CLEAR   = 3'd0,
    F_ALLOC   = 3'd1,
    F_QUERY   = 3'd2,
    F_PLACE   = 3'd3,
    F_RELEASE = 3'd4,
    F_MOVE    = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOB     = 2'd1,
    ST_BLOCKED = 2'd2,
    ST_NOFIT   = 2'd3
  } status_t;

  // which rectangle a row pass works on
  typedef enum logic [1:0] {
    SEL_OLD,
    SEL_NEW,
    SEL_FOUND
  } rsel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_UNPAINT,
    S_TEST,
    S_PAINT,
    S_SCAN,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    logic    clear;
    logic    start;
    logic    start_scan;
    rsel_t   start_sel;
    rsel_t   sel;
    logic    paint_set;
    logic    paint_clr;
    logic    test_en;
    logic    scan_en;
    logic    emit;
    status_t emit_st;
    logic    emit_pos;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [FUNCW-1:0] func;
    logic             oob_old;
    logic             oob_new;
    logic             alloc_zero;
    logic             alloc_big;
    logic             hit_any;
    logic             found;
    logic             paint_last;
    logic             test_last;
    logic             scan_last;
  } sts_t;

  // columns c with lo <= c < hi and c < lim
  function automatic logic [MAX_COLS-1:0] col_mask(input logic [EW-1:0] lo,
                                                   input logic [EW-1:0] hi,
                                                   input logic [EW-1:0] lim);
    logic [MAX_COLS-1:0] m;
    for (int i = 0; i < MAX_COLS; i++) begin
      m[i] = (EW'(i) >= lo) && (EW'(i) < hi) && (EW'(i) < lim);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

[rtl/grba_ctrl.sv]
`default_nettype none
module grba_ctrl
  import grba_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;
  rsel_t   sel_r, sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_OK;
      sel_r   <= SEL_OLD;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
      sel_r   <= sel_nxt;
    end
  end

  // next state, pending status and rectangle of the next pass
  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    sel_nxt   = sel_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.func)
          F_CLEAR: begin
            st_nxt    = ST_OK;
            state_nxt = S_DONE;
          end
          F_ALLOC: begin
            if (sts.alloc_zero) begin
              st_nxt    = ST_OOB;
              state_nxt = S_DONE;
            end else if (sts.alloc_big) begin
              st_nxt    = ST_NOFIT;
              state_nxt = S_DONE;
            end else begin
              st_nxt    = ST_NOFIT;
              state_nxt = S_SCAN;
            end
          end
          F_QUERY, F_PLACE: begin
            sel_nxt = SEL_OLD;
            if (sts.oob_old) begin
              st_nxt    = ST_OOB;
              state_nxt = S_DONE;
            end else begin
              st_nxt    = ST_OK;
              state_nxt = S_TEST;
            end
          end
          F_RELEASE, F_MOVE: begin
            sel_nxt   = SEL_OLD;
            st_nxt    = ST_OK;
            state_nxt = S_UNPAINT;
          end
          default: begin
            st_nxt    = ST_OK;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_UNPAINT: begin
        if (sts.paint_last) begin
          if (sts.func == F_MOVE) begin
            if (sts.oob_new) begin
              // restore old spot
              st_nxt    = ST_OOB;
              sel_nxt   = SEL_OLD;
              state_nxt = S_PAINT;
            end else begin
              sel_nxt   = SEL_NEW;
              state_nxt = S_TEST;
            end
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_TEST: begin
        if (sts.test_last) begin
          if (sts.hit_any) begin
            st_nxt = ST_BLOCKED;
            if (sts.func == F_MOVE) begin
              sel_nxt   = SEL_OLD;
              state_nxt = S_PAINT;
            end else begin
              state_nxt = S_DONE;
            end
          end else begin
            st_nxt = ST_OK;
            if (sts.func == F_PLACE || sts.func == F_MOVE) begin
              state_nxt = S_PAINT;
            end else begin
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_PAINT: begin
        if (sts.paint_last) begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        if (sts.found) begin
          st_nxt    = ST_OK;
          sel_nxt   = SEL_FOUND;
          state_nxt = S_PAINT;
        end else if (sts.scan_last) begin
          st_nxt    = ST_NOFIT;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath commands
  always_comb begin
    cmd            = '0;
    cmd.load       = (state_r == S_IDLE) && start;
    cmd.clear      = (state_r == S_DECODE) && (sts.func == F_CLEAR);
    cmd.sel        = sel_r;
    cmd.paint_clr  = (state_r == S_UNPAINT);
    cmd.test_en    = (state_r == S_TEST);
    cmd.paint_set  = (state_r == S_PAINT);
    cmd.scan_en    = (state_r == S_SCAN);
    cmd.start      = (state_nxt != state_r) &&
                     (state_nxt inside {S_UNPAINT, S_TEST, S_PAINT, S_SCAN});
    cmd.start_sel  = sel_nxt;
    cmd.start_scan = (state_nxt == S_SCAN) && (state_r != S_SCAN);
    cmd.emit       = (state_r == S_DONE);
    cmd.emit_st    = st_r;
    cmd.emit_pos   = (sts.func == F_ALLOC) && (st_r == ST_OK);
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

[rtl/grba_dp.sv]
`default_nettype none
module grba_dp
  import grba_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [FUNCW-1:0]  in_func,
  input  wire logic [XW-1:0]     in_pos_x,
  input  wire logic [YW-1:0]     in_pos_y,
  input  wire logic [SZW-1:0]    in_rect_w,
  input  wire logic [SZW-1:0]    in_rect_h,
  input  wire logic [XW-1:0]     in_new_x,
  input  wire logic [YW-1:0]     in_new_y,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFGW-1:0]   cfg_data,
  input  wire cmd_t              cmd,
  output sts_t                   sts,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output logic [XW-1:0]          out_x,
  output logic [YW-1:0]          out_y
);

  // latched item
  logic [FUNCW-1:0] func_r;
  logic [XW-1:0]    px_r, nx_r;
  logic [YW-1:0]    py_r, ny_r;
  logic [SZW-1:0]   w_r, h_r;

  // config and grid
  logic [CFGW-1:0]     cols_cfg_r, rows_cfg_r;
  logic [MAX_COLS-1:0] occ_r [MAX_ROWS];

  // row walker and scan state
  logic [RW-1:0]   r_r;
  logic            blocked_r;
  logic [RUNW-1:0] run_r   [MAX_COLS];
  logic [RUNW-1:0] run_nxt [MAX_COLS];
  logic [XW-1:0]   fx_r;
  logic [YW-1:0]   fy_r;

  logic          out_valid_r;
  status_t       out_status_r;
  logic [XW-1:0] out_x_r;
  logic [YW-1:0] out_y_r;

  logic [EW-1:0]       cols_e, rows_e, w_e, h_e, r_e;
  logic [EW-1:0]       sx, sy, ye, st_y;
  logic [MAX_COLS-1:0] row_rd, m_sel, free_v, fits;
  logic                row_hit, paint_active, found_now;
  logic [XW-1:0]       fx_now;
  logic [YW-1:0]       fy_now;

  assign cfg_ready = 1'b1;

  // grid size in use, clamped to 1..MAX
  always_comb begin
    if (cols_cfg_r == '0) begin
      cols_e = EW'(1);
    end else if (EW'(cols_cfg_r) > EW'(MAX_COLS)) begin
      cols_e = EW'(MAX_COLS);
    end else begin
      cols_e = EW'(cols_cfg_r);
    end
    if (rows_cfg_r == '0) begin
      rows_e = EW'(1);
    end else if (EW'(rows_cfg_r) > EW'(MAX_ROWS)) begin
      rows_e = EW'(MAX_ROWS);
    end else begin
      rows_e = EW'(rows_cfg_r);
    end
  end

  assign w_e = EW'(w_r);
  assign h_e = EW'(h_r);
  assign r_e = EW'(r_r);

  // rectangle of the current pass
  always_comb begin
    case (cmd.sel)
      SEL_OLD: begin
        sx = EW'(px_r);
        sy = EW'(py_r);
      end
      SEL_NEW: begin
        sx = EW'(nx_r);
        sy = EW'(ny_r);
      end
      SEL_FOUND: begin
        sx = EW'(fx_r);
        sy = EW'(fy_r);
      end
      default: begin
        sx = EW'(px_r);
        sy = EW'(py_r);
      end
    endcase
  end

  // first row of the next pass
  always_comb begin
    case (cmd.start_sel)
      SEL_OLD:   st_y = EW'(py_r);
      SEL_NEW:   st_y = EW'(ny_r);
      SEL_FOUND: st_y = EW'(fy_now);
      default:   st_y = EW'(py_r);
    endcase
  end

  // current row: overlap test and paint window
  assign ye           = sy + h_e;
  assign row_rd       = occ_r[r_r];
  assign m_sel        = col_mask(sx, sx + w_e, cols_e);
  assign row_hit      = |(row_rd & m_sel);
  assign paint_active = (r_e < ye) && (r_e < rows_e);

  // first-fit scan: per-column count of free rows ending at this row
  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      run_nxt[c] = row_rd[c] ? '0 : run_r[c] + RUNW'(1);
      free_v[c]  = (EW'(run_nxt[c]) >= h_e);
    end
    for (int c = 0; c < MAX_COLS; c++) begin
      fits[c] = (EW'(c) + w_e <= cols_e) &&
                ((~free_v & col_mask(EW'(c), EW'(c) + w_e, cols_e)) == '0);
    end
    found_now = 1'b0;
    fx_now    = '0;
    for (int c = MAX_COLS - 1; c >= 0; c--) begin
      if (fits[c]) begin
        found_now = 1'b1;
        fx_now    = XW'(c);
      end
    end
    fy_now = YW'(r_e + EW'(1) - h_e);
  end

  // status to the controller
  always_comb begin
    sts            = '0;
    sts.func       = func_r;
    sts.oob_old    = (w_r == '0) || (h_r == '0) ||
                     (EW'(px_r) + w_e > cols_e) || (EW'(py_r) + h_e > rows_e);
    sts.oob_new    = (w_r == '0) || (h_r == '0) ||
                     (EW'(nx_r) + w_e > cols_e) || (EW'(ny_r) + h_e > rows_e);
    sts.alloc_zero = (w_r == '0) || (h_r == '0);
    sts.alloc_big  = (w_e > cols_e) || (h_e > rows_e);
    sts.hit_any    = blocked_r | row_hit;
    sts.found      = found_now;
    sts.paint_last = !((r_e + EW'(1) < ye) && (r_e + EW'(1) < rows_e));
    sts.test_last  = (r_e + EW'(1) == ye);
    sts.scan_last  = (r_e + EW'(1) == rows_e);
  end

  // config, grid, walker and strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r  <= GRID_COLS_RST;
      rows_cfg_r  <= GRID_ROWS_RST;
      r_r         <= '0;
      blocked_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_ROWS; i++) begin
        occ_r[i] <= '0;
      end
      for (int c = 0; c < MAX_COLS; c++) begin
        run_r[c] <= '0;
      end
    end else begin
      out_valid_r <= cmd.emit;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_GRID_COLS) begin
          cols_cfg_r <= cfg_data;
        end
        if (cfg_index == REG_GRID_ROWS) begin
          rows_cfg_r <= cfg_data;
        end
      end
      if (cmd.clear) begin
        for (int i = 0; i < MAX_ROWS; i++) begin
          occ_r[i] <= '0;
        end
      end else if (paint_active && cmd.paint_set) begin
        occ_r[r_r] <= row_rd | m_sel;
      end else if (paint_active && cmd.paint_clr) begin
        occ_r[r_r] <= row_rd & ~m_sel;
      end
      if (cmd.start) begin
        r_r       <= cmd.start_scan ? '0 : RW'(st_y);
        blocked_r <= 1'b0;
        if (cmd.start_scan) begin
          for (int c = 0; c < MAX_COLS; c++) begin
            run_r[c] <= '0;
          end
        end
      end else if (cmd.paint_set || cmd.paint_clr || cmd.test_en || cmd.scan_en) begin
        r_r <= r_r + RW'(1);
        if (cmd.test_en) begin
          blocked_r <= blocked_r | row_hit;
        end
        if (cmd.scan_en) begin
          run_r <= run_nxt;
        end
      end
    end
  end

  // item, found spot and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      px_r   <= in_pos_x;
      py_r   <= in_pos_y;
      w_r    <= in_rect_w;
      h_r    <= in_rect_h;
      nx_r   <= in_new_x;
      ny_r   <= in_new_y;
    end
    if (cmd.scan_en && found_now) begin
      fx_r <= fx_now;
      fy_r <= fy_now;
    end
    if (cmd.emit) begin
      out_status_r <= cmd.emit_st;
      out_x_r      <= cmd.emit_pos ? fx_r : '0;
      out_y_r      <= cmd.emit_pos ? fy_r : '0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_x      = out_x_r;
  assign out_y      = out_y_r;

endmodule
`default_nettype wire

[rtl/grid_rect_bitmap_allocator.sv]
// Rectangle allocator over an occupancy bitmap of up to 16 x 16 cells, one
// register word per row. An item is taken when start is high and busy is low;
// exactly one result follows as a single-cycle out_valid strobe that the
// receiver cannot hold off, so it must be captured on that cycle. Every
// operation but clear walks the grid one row per cycle through a single row
// read/write port, clear empties every row at once. Query, place, release
// and move walk the rows of their rectangles; first-fit allocate scans rows
// until a fit is found or the last row in use is reached.
// Allocate keeps a free-row run count per column so each scanned row tests
// every column window at once. Config writes are always ready and are to be
// issued only while busy is low and no result is pending; changing the grid
// size does not clear the bitmap.
`default_nettype none
module grid_rect_bitmap_allocator
  import grba_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [FUNCW-1:0]  in_func,
  input  wire logic [XW-1:0]     in_pos_x,
  input  wire logic [YW-1:0]     in_pos_y,
  input  wire logic [SZW-1:0]    in_rect_w,
  input  wire logic [SZW-1:0]    in_rect_h,
  input  wire logic [XW-1:0]     in_new_x,
  input  wire logic [YW-1:0]     in_new_y,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [CFGW-1:0]   cfg_data,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output logic [XW-1:0]          out_x,
  output logic [YW-1:0]          out_y
);

  cmd_t cmd;
  sts_t sts;

  grba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  grba_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_func    (in_func),
    .in_pos_x   (in_pos_x),
    .in_pos_y   (in_pos_y),
    .in_rect_w  (in_rect_w),
    .in_rect_h  (in_rect_h),
    .in_new_x   (in_new_x),
    .in_new_y   (in_new_y),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_x      (out_x),
    .out_y      (out_y)
  );

endmodule
`default_nettype wire

[rtl/grba_checker.sv]
`default_nettype none
module grba_checker
  import grba_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire logic [1:0]        out_status,
  input wire logic [XW-1:0]     out_x,
  input wire logic [YW-1:0]     out_y
);

  // an accepted beat always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  // results never come on back-to-back cycles
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // a result closes an operation
  a_result_ends_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result without a finished operation");

  // failed operations report no position
  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_x == '0) && (out_y == '0))
    else $error("position reported on failure");

endmodule

bind grid_rect_bitmap_allocator grba_checker u_grba_checker (.*);
`default_nettype wire
